FILE: hdl/twsd_pkg.sv
// twsd_pkg: shared types and constants of the track to wire signed distance block
// payload structs, configuration codes and the job queue geometry
// no dependencies
`default_nettype none

package twsd_pkg;

    // input item of the block
    typedef struct packed {
        logic               func;
        logic [3:0]         layer;
        logic [4:0]         wire_req;
        logic signed [31:0] slope_x;
        logic signed [31:0] intercept_x;
        logic signed [31:0] slope_z;
        logic signed [31:0] intercept_z;
        logic signed [31:0] hv_end_x;
        logic signed [31:0] hv_end_y;
        logic signed [31:0] ro_end_x;
        logic signed [31:0] ro_end_y;
    } t_in;

    // result item of the block
    typedef struct packed {
        logic signed [31:0] signed_distance;
        logic               lines_parallel;
    } t_out;

    // distance job: track plus the wire end points looked up in the table
    typedef struct packed {
        logic signed [31:0] slope_x;
        logic signed [31:0] intercept_x;
        logic signed [31:0] slope_z;
        logic signed [31:0] intercept_z;
        logic signed [31:0] hv_x;
        logic signed [31:0] hv_y;
        logic signed [31:0] ro_x;
        logic signed [31:0] ro_y;
    } t_job;

    // configuration register values
    typedef struct packed {
        logic signed [31:0] upper_plane_y;
        logic signed [31:0] lower_plane_y;
        logic [30:0]        wire_half_length;
    } t_cfg;

    // job queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QLVL_W      = 3;

    // job handed from the front to the queue
    typedef struct packed {
        logic valid;
        t_job job;
    } t_beat;

    // queue status seen by front and back
    typedef struct packed {
        logic              empty;
        logic [QLVL_W-1:0] level;
    } t_qstat;

    // item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_DIST  = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_Y   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_LEN  = 2'd2;

endpackage

`default_nettype wire

FILE: hdl/track_wire_signed_distance.sv
// track_wire_signed_distance: top level, configuration registers and the three parts
// depends on twsd_pkg, twsd_front, twsd_queue and twsd_back
//
// channel   direction  handshake                    payload
// in        input      i_in_valid / o_in_ready      i_in_data  (twsd_pkg::t_in)
// out       output     o_out_valid / i_out_ready    o_out_data (twsd_pkg::t_out)
// cfg       input      i_cfg_we                     i_cfg_index, i_cfg_data
//
// one item per cycle while the output and the job queue do not stall; a distance item
// goes through the 29-stage square root and the 32-stage divider on its way out
// after reset the tables are cleared while o_in_ready is held low;
// configuration writes are taken at once
// a stalled output holds the whole distance pipeline; the front keeps taking
// items until the four-entry job queue is full
`default_nettype none

module track_wire_signed_distance #(
    parameter int LAYER_COUNT     = 16,
    parameter int WIRES_PER_LAYER = 32
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_in_valid,
    output logic                                   o_in_ready,
    input  twsd_pkg::t_in                          i_in_data,
    output logic                                   o_out_valid,
    input  wire                                    i_out_ready,
    output twsd_pkg::t_out                         o_out_data,
    input  wire                                    i_cfg_we,
    input  wire  [twsd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire  [31:0]                            i_cfg_data
);

    twsd_pkg::t_cfg   r_cfg;
    twsd_pkg::t_beat  push;
    twsd_pkg::t_qstat qstat;
    twsd_pkg::t_job   job;
    logic             pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                twsd_pkg::CFG_UPPER_Y:  r_cfg.upper_plane_y    <= i_cfg_data;
                twsd_pkg::CFG_LOWER_Y:  r_cfg.lower_plane_y    <= i_cfg_data;
                twsd_pkg::CFG_HALF_LEN: r_cfg.wire_half_length <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // front: accept, table, job build
    twsd_front #(
        .LAYER_COUNT     (LAYER_COUNT),
        .WIRES_PER_LAYER (WIRES_PER_LAYER)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_qstat    (qstat),
        .o_push     (push)
    );

    // job queue
    twsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_job   (job),
        .o_qstat (qstat)
    );

    // back: distance pipeline
    twsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (job),
        .i_job_avail (!qstat.empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: hdl/twsd_front.sv
// twsd_front: accepts items, keeps the wire end point tables and builds distance jobs
// depends on twsd_pkg; clears the tables after reset before taking items
`default_nettype none

module twsd_front #(
    parameter int LAYER_COUNT     = 16,
    parameter int WIRES_PER_LAYER = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  twsd_pkg::t_in       i_in_data,
    input  twsd_pkg::t_qstat    i_qstat,
    output twsd_pkg::t_beat     o_push
);

    localparam int DEPTH    = LAYER_COUNT * WIRES_PER_LAYER;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QLVL_W_L = twsd_pkg::QLVL_W;

    logic [63:0]        r_hv_mem [DEPTH];
    logic [63:0]        r_ro_mem [DEPTH];
    logic [63:0]        r_hv_rd;
    logic [63:0]        r_ro_rd;
    logic               r_clearing;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic               r_s1_valid;
    logic               r_s1_hit;
    logic signed [31:0] r_s1_slx;
    logic signed [31:0] r_s1_inx;
    logic signed [31:0] r_s1_slz;
    logic signed [31:0] r_s1_inz;

    logic [31:0]        n_idx;
    logic               n_hit;
    logic [ADDR_W-1:0]  n_addr;
    logic               n_accept;
    logic               n_we;
    logic [ADDR_W-1:0]  n_waddr;
    logic [63:0]        n_hv_wd;
    logic [63:0]        n_ro_wd;
    logic [QLVL_W_L-1:0] n_used;

    // table index and range check
    always_comb begin
        n_idx  = 32'(i_in_data.layer) * 32'(WIRES_PER_LAYER) + 32'(i_in_data.wire_req);
        n_hit  = (32'(i_in_data.layer) < 32'(LAYER_COUNT)) &&
                 (32'(i_in_data.wire_req) < 32'(WIRES_PER_LAYER));
        n_addr = n_hit ? n_idx[ADDR_W-1:0] : '0;
    end

    // room in the queue counting the job still in the lookup stage
    assign n_used     = i_qstat.level + QLVL_W_L'(r_s1_valid);
    assign o_in_ready = !r_clearing && (n_used < QLVL_W_L'(twsd_pkg::QUEUE_DEPTH));
    assign n_accept   = i_in_valid && o_in_ready;

    // table write port: clearing sweep or a write item
    always_comb begin
        if (r_clearing) begin
            n_we    = 1'b1;
            n_waddr = r_clr_addr;
            n_hv_wd = '0;
            n_ro_wd = '0;
        end else begin
            n_we    = n_accept && (i_in_data.func == twsd_pkg::FUNC_WRITE) && n_hit;
            n_waddr = n_addr;
            n_hv_wd = {i_in_data.hv_end_x, i_in_data.hv_end_y};
            n_ro_wd = {i_in_data.ro_end_x, i_in_data.ro_end_y};
        end
    end

    // wire end point tables
    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_hv_mem[n_waddr] <= n_hv_wd;
            r_ro_mem[n_waddr] <= n_ro_wd;
        end
        r_hv_rd <= r_hv_mem[n_addr];
        r_ro_rd <= r_ro_mem[n_addr];
    end

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // lookup stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_accept && (i_in_data.func == twsd_pkg::FUNC_DIST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_s1_hit <= n_hit;
            r_s1_slx <= i_in_data.slope_x;
            r_s1_inx <= i_in_data.intercept_x;
            r_s1_slz <= i_in_data.slope_z;
            r_s1_inz <= i_in_data.intercept_z;
        end
    end

    // job to the queue, unknown wires read as zero
    always_comb begin
        o_push.valid           = r_s1_valid;
        o_push.job.slope_x     = r_s1_slx;
        o_push.job.intercept_x = r_s1_inx;
        o_push.job.slope_z     = r_s1_slz;
        o_push.job.intercept_z = r_s1_inz;
        o_push.job.hv_x        = r_s1_hit ? r_hv_rd[63:32] : '0;
        o_push.job.hv_y        = r_s1_hit ? r_hv_rd[31:0]  : '0;
        o_push.job.ro_x        = r_s1_hit ? r_ro_rd[63:32] : '0;
        o_push.job.ro_y        = r_s1_hit ? r_ro_rd[31:0]  : '0;
    end

endmodule

`default_nettype wire

FILE: hdl/twsd_queue.sv
// twsd_queue: short job queue between the front and the distance pipeline
// depends on twsd_pkg for the job type and the queue geometry
`default_nettype none

module twsd_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  twsd_pkg::t_beat     i_push,
    input  wire                 i_pop,
    output twsd_pkg::t_job      o_job,
    output twsd_pkg::t_qstat    o_qstat
);

    localparam int PW = twsd_pkg::QPTR_W;
    localparam int LW = twsd_pkg::QLVL_W;

    twsd_pkg::t_job r_mem [twsd_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [LW-1:0]  r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + LW'(i_push.valid) - LW'(i_pop);
        end
    end

    assign o_job         = r_mem[r_rd_ptr];
    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.level = r_count;

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> r_count != LW'(twsd_pkg::QUEUE_DEPTH))
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("job popped from an empty queue");

    a_level_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_count == $past(r_count) + LW'($past(i_push.valid)) - LW'($past(i_pop)))
        else $error("queue level out of step with pushes and pops");
`endif

endmodule

`default_nettype wire

FILE: hdl/twsd_back.sv
// twsd_back: distance pipeline from a job to a result item
// cross product, normalize, dot product, pipelined square root and divider
// depends on twsd_pkg; the whole pipeline advances when the output register can move
`default_nettype none

module twsd_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  twsd_pkg::t_cfg      i_cfg,
    input  twsd_pkg::t_job      i_job,
    input  wire                 i_job_avail,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output twsd_pkg::t_out      o_out_data
);

    localparam int SQ_STEPS  = 29;
    localparam int DIV_STEPS = 32;

    logic adv;

    // stage valids
    logic [10:1] r_v;
    logic        r_sq_v [SQ_STEPS+1];
    logic        r_nv;
    logic        r_dv_v [DIV_STEPS+1];
    logic        r_out_valid;

    // stage 1: differences
    logic signed [32:0] r1_wx, r1_wy, r1_dx, r1_dy, r1_dz;
    logic signed [31:0] r1_slx, r1_slz;
    logic [30:0]        r1_len;
    logic               r1_hneg, r1_hzero;
    // stage 2: products of the cross product
    logic signed [64:0] r2_p [4];
    logic signed [32:0] r2_wx, r2_dx, r2_dy, r2_dz;
    logic [30:0]        r2_len;
    logic               r2_hneg, r2_hzero;
    // stage 3: cross product
    logic signed [65:0] r3_c [3];
    logic signed [32:0] r3_dx, r3_dy, r3_dz;
    logic               r3_hneg, r3_hzero;
    // stage 4: sign and magnitude
    logic [63:0]        r4_m [3];
    logic [2:0]         r4_ng;
    logic signed [32:0] r4_dx, r4_dy, r4_dz;
    logic               r4_hneg, r4_hzero;
    // stage 5: largest magnitude
    logic [63:0]        r5_mx;
    logic [63:0]        r5_m [3];
    logic [2:0]         r5_ng;
    logic signed [32:0] r5_dx, r5_dy, r5_dz;
    logic               r5_hneg, r5_hzero;
    // stage 6: leading one per byte
    logic [7:0]         r6_nz;
    logic [2:0]         r6_pos [8];
    logic [63:0]        r6_m [3];
    logic [2:0]         r6_ng;
    logic signed [32:0] r6_dx, r6_dy, r6_dz;
    logic               r6_hneg, r6_hzero;
    // stage 7: leading one position
    logic [5:0]         r7_p;
    logic               r7_par;
    logic [63:0]        r7_m [3];
    logic [2:0]         r7_ng;
    logic signed [32:0] r7_dx, r7_dy, r7_dz;
    logic               r7_hneg;
    // stage 8: normalized magnitudes
    logic [27:0]        r8_m [3];
    logic [2:0]         r8_ng;
    logic signed [32:0] r8_dx, r8_dy, r8_dz;
    logic               r8_hneg, r8_par;
    // stage 9: dot terms and squares
    logic signed [61:0] r9_t [3];
    logic [55:0]        r9_q [3];
    logic               r9_hneg, r9_par;
    // stage 10: sums
    logic signed [63:0] r10_dot;
    logic [57:0]        r10_ss;
    logic               r10_hneg, r10_par;
    // square root stages
    logic [57:0]        r_sq_rad  [SQ_STEPS+1];
    logic [31:0]        r_sq_rem  [SQ_STEPS+1];
    logic [28:0]        r_sq_root [SQ_STEPS+1];
    logic [62:0]        r_sq_dmag [SQ_STEPS+1];
    logic               r_sq_neg  [SQ_STEPS+1];
    logic               r_sq_par  [SQ_STEPS+1];
    // rounded numerator
    logic [63:0]        r_n_num;
    logic [28:0]        r_n_d;
    logic               r_n_neg, r_n_par;
    // divider stages
    logic [63:0]        r_dv_rem [DIV_STEPS+1];
    logic [31:0]        r_dv_q   [DIV_STEPS+1];
    logic [28:0]        r_dv_d   [DIV_STEPS+1];
    logic               r_dv_neg [DIV_STEPS+1];
    logic               r_dv_par [DIV_STEPS+1];
    logic               r_dv_sat [DIV_STEPS+1];
    twsd_pkg::t_out     r_out;

    // combinational helpers
    logic signed [32:0] n_wz;
    logic signed [65:0] n_c [3];
    logic [65:0]        n_cneg [3];
    logic [63:0]        n_mx;
    logic [2:0]         n_pos [8];
    logic [5:0]         n_p;
    logic [5:0]         n_sh;
    logic [63:0]        n_msh [3];
    logic signed [28:0] n_cn [3];
    logic [63:0]        n_dneg;
    logic [31:0]        n_sq_cur  [SQ_STEPS];
    logic [31:0]        n_sq_try  [SQ_STEPS];
    logic [31:0]        n_sq_rem  [SQ_STEPS];
    logic [28:0]        n_sq_root [SQ_STEPS];
    logic [63:0]        n_dv_sub  [DIV_STEPS];
    logic [63:0]        n_dv_rem  [DIV_STEPS];
    logic [31:0]        n_dv_q    [DIV_STEPS];
    twsd_pkg::t_out     n_out;

    assign adv   = !r_out_valid || i_out_ready;
    assign o_pop = adv && i_job_avail;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_nv        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k <= SQ_STEPS; k++) r_sq_v[k] <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++) r_dv_v[k] <= 1'b0;
        end else if (adv) begin
            r_v         <= {r_v[9:1], o_pop};
            r_sq_v[0]   <= r_v[10];
            for (int k = 0; k < SQ_STEPS; k++) r_sq_v[k+1] <= r_sq_v[k];
            r_nv        <= r_sq_v[SQ_STEPS];
            r_dv_v[0]   <= r_nv;
            for (int k = 0; k < DIV_STEPS; k++) r_dv_v[k+1] <= r_dv_v[k];
            r_out_valid <= r_dv_v[DIV_STEPS];
        end
    end

    // stages 1 to 3: differences, products, cross product
    assign n_wz = {1'b0, r1_len, 1'b0};

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_wx    <= {i_job.ro_x[31], i_job.ro_x} - {i_job.hv_x[31], i_job.hv_x};
            r1_wy    <= {i_job.ro_y[31], i_job.ro_y} - {i_job.hv_y[31], i_job.hv_y};
            r1_dx    <= {i_job.hv_x[31], i_job.hv_x} - {i_job.intercept_x[31], i_job.intercept_x};
            r1_dy    <= {i_job.hv_y[31], i_job.hv_y} -
                        {i_cfg.upper_plane_y[31], i_cfg.upper_plane_y};
            r1_dz    <= 33'd0 - {2'b00, i_cfg.wire_half_length} -
                        {i_job.intercept_z[31], i_job.intercept_z};
            r1_slx   <= i_job.slope_x;
            r1_slz   <= i_job.slope_z;
            r1_len   <= i_cfg.wire_half_length;
            r1_hneg  <= ({i_cfg.upper_plane_y[31], i_cfg.upper_plane_y} -
                         {i_cfg.lower_plane_y[31], i_cfg.lower_plane_y}) >> 32 != 33'd0;
            r1_hzero <= (i_cfg.upper_plane_y == i_cfg.lower_plane_y);

            r2_p[0]  <= r1_wy * r1_slz;
            r2_p[1]  <= n_wz * r1_slx;
            r2_p[2]  <= r1_wx * r1_slz;
            r2_p[3]  <= r1_wy * r1_slx;
            r2_wx    <= r1_wx;
            r2_len   <= r1_len;
            r2_dx    <= r1_dx;
            r2_dy    <= r1_dy;
            r2_dz    <= r1_dz;
            r2_hneg  <= r1_hneg;
            r2_hzero <= r1_hzero;

            r3_c[0]  <= {r2_p[0][64], r2_p[0]} - {18'd0, r2_len, 17'd0};
            r3_c[1]  <= {r2_p[1][64], r2_p[1]} - {r2_p[2][64], r2_p[2]};
            r3_c[2]  <= {{17{r2_wx[32]}}, r2_wx, 16'd0} - {r2_p[3][64], r2_p[3]};
            r3_dx    <= r2_dx;
            r3_dy    <= r2_dy;
            r3_dz    <= r2_dz;
            r3_hneg  <= r2_hneg;
            r3_hzero <= r2_hzero;
        end
    end

    // sign and magnitude, largest magnitude, leading one per byte
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_c[i]    = r3_c[i];
            n_cneg[i] = 66'd0 - n_c[i];
        end
        n_mx = r4_m[0];
        if (r4_m[1] > n_mx) n_mx = r4_m[1];
        if (r4_m[2] > n_mx) n_mx = r4_m[2];
        for (int j = 0; j < 8; j++) begin
            n_pos[j] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (r5_mx[8*j+b]) n_pos[j] = 3'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r4_m[i]  <= r3_c[i][65] ? n_cneg[i][63:0] : r3_c[i][63:0];
                r4_ng[i] <= r3_c[i][65];
                r5_m[i]  <= r4_m[i];
                r6_m[i]  <= r5_m[i];
                r7_m[i]  <= r6_m[i];
            end
            r4_dx    <= r3_dx;
            r4_dy    <= r3_dy;
            r4_dz    <= r3_dz;
            r4_hneg  <= r3_hneg;
            r4_hzero <= r3_hzero;

            r5_mx    <= n_mx;
            r5_ng    <= r4_ng;
            r5_dx    <= r4_dx;
            r5_dy    <= r4_dy;
            r5_dz    <= r4_dz;
            r5_hneg  <= r4_hneg;
            r5_hzero <= r4_hzero;

            for (int j = 0; j < 8; j++) begin
                r6_nz[j]  <= |r5_mx[8*j +: 8];
                r6_pos[j] <= n_pos[j];
            end
            r6_ng    <= r5_ng;
            r6_dx    <= r5_dx;
            r6_dy    <= r5_dy;
            r6_dz    <= r5_dz;
            r6_hneg  <= r5_hneg;
            r6_hzero <= r5_hzero;

            r7_p     <= n_p;
            r7_par   <= r6_hzero || (r6_nz == 8'd0);
            r7_ng    <= r6_ng;
            r7_dx    <= r6_dx;
            r7_dy    <= r6_dy;
            r7_dz    <= r6_dz;
            r7_hneg  <= r6_hneg;
        end
    end

    // leading one position from the byte flags
    always_comb begin
        n_p = 6'd0;
        for (int j = 0; j < 8; j++) begin
            if (r6_nz[j]) n_p = {3'(j), r6_pos[j]};
        end
    end

    // normalizing shift: leading one of the largest magnitude lands on bit 27
    always_comb begin
        n_sh = (r7_p >= 6'd28) ? (r7_p - 6'd27) : (6'd27 - r7_p);
        for (int i = 0; i < 3; i++) begin
            n_msh[i] = (r7_p >= 6'd28) ? (r7_m[i] >> n_sh) : (r7_m[i] << n_sh);
            n_cn[i]  = r8_ng[i] ? (29'd0 - {1'b0, r8_m[i]}) : {1'b0, r8_m[i]};
        end
        n_dneg = 64'd0 - r10_dot;
    end

    // stages 8 to 10: normalized cross product, dot product and squared norm
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r8_m[i] <= n_msh[i][27:0];
                r9_q[i] <= r8_m[i] * r8_m[i];
            end
            r8_ng    <= r7_ng;
            r8_dx    <= r7_dx;
            r8_dy    <= r7_dy;
            r8_dz    <= r7_dz;
            r8_hneg  <= r7_hneg;
            r8_par   <= r7_par;

            r9_t[0]  <= r8_dx * n_cn[0];
            r9_t[1]  <= r8_dy * n_cn[1];
            r9_t[2]  <= r8_dz * n_cn[2];
            r9_hneg  <= r8_hneg;
            r9_par   <= r8_par;

            r10_dot  <= 64'(r9_t[0]) + 64'(r9_t[1]) + 64'(r9_t[2]);
            r10_ss   <= 58'(r9_q[0]) + 58'(r9_q[1]) + 58'(r9_q[2]);
            r10_hneg <= r9_hneg;
            r10_par  <= r9_par;
        end
    end

    // square root: two radicand bits per stage
    always_comb begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            n_sq_cur[k] = {r_sq_rem[k][29:0], r_sq_rad[k][57:56]};
            n_sq_try[k] = {1'b0, r_sq_root[k], 2'b01};
            if (n_sq_cur[k] >= n_sq_try[k]) begin
                n_sq_rem[k]  = n_sq_cur[k] - n_sq_try[k];
                n_sq_root[k] = {r_sq_root[k][27:0], 1'b1};
            end else begin
                n_sq_rem[k]  = n_sq_cur[k];
                n_sq_root[k] = {r_sq_root[k][27:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_rad[0]  <= r10_ss;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_dmag[0] <= r10_dot[63] ? n_dneg[62:0] : r10_dot[62:0];
            r_sq_neg[0]  <= r10_dot[63] ^ r10_hneg;
            r_sq_par[0]  <= r10_par;
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_sq_rad[k+1]  <= {r_sq_rad[k][55:0], 2'b00};
                r_sq_rem[k+1]  <= n_sq_rem[k];
                r_sq_root[k+1] <= n_sq_root[k];
                r_sq_dmag[k+1] <= r_sq_dmag[k];
                r_sq_neg[k+1]  <= r_sq_neg[k];
                r_sq_par[k+1]  <= r_sq_par[k];
            end
        end
    end

    // divider: one quotient bit per stage, saturation checked up front
    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            n_dv_sub[k] = {35'd0, r_dv_d[k]} << (DIV_STEPS - 1 - k);
            if (r_dv_rem[k] >= n_dv_sub[k]) begin
                n_dv_rem[k] = r_dv_rem[k] - n_dv_sub[k];
                n_dv_q[k]   = {r_dv_q[k][30:0], 1'b1};
            end else begin
                n_dv_rem[k] = r_dv_rem[k];
                n_dv_q[k]   = {r_dv_q[k][30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_n_num     <= {1'b0, r_sq_dmag[SQ_STEPS]} + {36'd0, r_sq_root[SQ_STEPS][28:1]};
            r_n_d       <= r_sq_root[SQ_STEPS];
            r_n_neg     <= r_sq_neg[SQ_STEPS];
            r_n_par     <= r_sq_par[SQ_STEPS];

            r_dv_rem[0] <= r_n_num;
            r_dv_q[0]   <= '0;
            r_dv_d[0]   <= r_n_d;
            r_dv_neg[0] <= r_n_neg;
            r_dv_par[0] <= r_n_par;
            r_dv_sat[0] <= r_n_num >= {3'b000, r_n_d, 32'd0};
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_dv_rem[k+1] <= n_dv_rem[k];
                r_dv_q[k+1]   <= n_dv_q[k];
                r_dv_d[k+1]   <= r_dv_d[k];
                r_dv_neg[k+1] <= r_dv_neg[k];
                r_dv_par[k+1] <= r_dv_par[k];
                r_dv_sat[k+1] <= r_dv_sat[k];
            end
            r_out <= n_out;
        end
    end

    // sign, saturation and the parallel case
    always_comb begin
        n_out.lines_parallel = r_dv_par[DIV_STEPS];
        if (r_dv_par[DIV_STEPS]) begin
            n_out.signed_distance = '0;
        end else if (r_dv_neg[DIV_STEPS]) begin
            if (r_dv_sat[DIV_STEPS] || (r_dv_q[DIV_STEPS] > 32'h8000_0000)) begin
                n_out.signed_distance = 32'sh8000_0000;
            end else begin
                n_out.signed_distance = 32'd0 - r_dv_q[DIV_STEPS];
            end
        end else begin
            if (r_dv_sat[DIV_STEPS] || r_dv_q[DIV_STEPS][31]) begin
                n_out.signed_distance = 32'sh7fff_ffff;
            end else begin
                n_out.signed_distance = r_dv_q[DIV_STEPS];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// tb_top: self-checking testbench of track_wire_signed_distance
// drives items and register writes, predicts each distance and checks it in order
// depends on twsd_pkg and track_wire_signed_distance
`timescale 1ns / 100ps

// expected distances in acceptance order, with the mirrored wire table and registers
class distance_scoreboard;
    logic [63:0] hv_mirror [0:511];
    logic [63:0] ro_mirror [0:511];
    logic signed [31:0] upper_y;
    logic signed [31:0] lower_y;
    logic [30:0] half_len;
    twsd_pkg::t_out pending_q[$];
    int n_errors;

    function new();
        for (int i = 0; i < 512; i++) begin
            hv_mirror[i] = '0;
            ro_mirror[i] = '0;
        end
        upper_y = '0;
        lower_y = '0;
        half_len = '0;
        n_errors = 0;
    endfunction

    function void write_reg(logic [twsd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        case (idx)
            twsd_pkg::CFG_UPPER_Y: begin
                upper_y = val;
            end
            twsd_pkg::CFG_LOWER_Y: begin
                lower_y = val;
            end
            twsd_pkg::CFG_HALF_LEN: begin
                half_len = val[30:0];
            end
            default: ;
        endcase
    endfunction

    // integer square root, floor
    function logic [63:0] root_floor(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // distance of closest approach for one distance item
    function twsd_pkg::t_out track_distance(twsd_pkg::t_in it);
        twsd_pkg::t_out r;
        logic [8:0] idx;
        logic signed [63:0] hx, hy, rx, ry, slx, inx, slz, inz, yu, yd, hl, h;
        logic signed [63:0] wx, wy, wz, dx, dy, dz, dot;
        logic signed [63:0] a[3];
        logic signed [63:0] b[3];
        logic signed [63:0] cn[3];
        logic [63:0] mag[3];
        logic ng[3];
        logic [63:0] mx, norm, dmag, q;
        int k;
        idx = {it.layer, it.wire_req};
        hx = $signed(hv_mirror[idx][63:32]);
        hy = $signed(hv_mirror[idx][31:0]);
        rx = $signed(ro_mirror[idx][63:32]);
        ry = $signed(ro_mirror[idx][31:0]);
        slx = it.slope_x; inx = it.intercept_x;
        slz = it.slope_z; inz = it.intercept_z;
        yu = upper_y; yd = lower_y;
        hl = {33'd0, half_len};
        h = yu - yd;
        wx = rx - hx; wy = ry - hy; wz = 2 * hl;
        a[0] = wy * slz; b[0] = wz * 65536;
        a[1] = wz * slx; b[1] = wx * slz;
        a[2] = wx * 65536; b[2] = wy * slx;
        for (int i = 0; i < 3; i++) begin
            ng[i] = a[i] < b[i];
            mag[i] = ng[i] ? b[i] - a[i] : a[i] - b[i];
        end
        mx = mag[0];
        if (mag[1] > mx) mx = mag[1];
        if (mag[2] > mx) mx = mag[2];
        r.signed_distance = '0;
        r.lines_parallel = 1'b1;
        if (h == 0 || mx == 0) return r;
        // common normalization into [2^27, 2^28)
        k = 0;
        if (mx >= (64'd1 << 28)) begin
            while ((mx >> k) >= (64'd1 << 28)) k++;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> k;
        end else begin
            while ((mx << k) < (64'd1 << 27)) k++;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << k;
        end
        for (int i = 0; i < 3; i++) cn[i] = ng[i] ? -$signed(mag[i]) : $signed(mag[i]);
        dx = hx - inx; dy = hy - yu; dz = -hl - inz;
        dot = dx * cn[0] + dy * cn[1] + dz * cn[2];
        norm = root_floor(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
        dmag = dot < 0 ? -dot : dot;
        q = (dmag + norm / 2) / norm;
        if ((dot < 0) != (h < 0)) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            r.signed_distance = 32'(64'd0 - q);
        end else begin
            if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
            r.signed_distance = 32'(q);
        end
        r.lines_parallel = 1'b0;
        return r;
    endfunction

    // note one accepted item
    function void note_item(twsd_pkg::t_in it);
        logic [8:0] idx;
        idx = {it.layer, it.wire_req};
        if (it.func == twsd_pkg::FUNC_WRITE) begin
            hv_mirror[idx] = {it.hv_end_x, it.hv_end_y};
            ro_mirror[idx] = {it.ro_end_x, it.ro_end_y};
        end else begin
            pending_q.insert(pending_q.size(), track_distance(it));
        end
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        n_errors++;
    endtask

    // compare one result with the oldest expectation
    task check_result(twsd_pkg::t_out got);
        twsd_pkg::t_out exp_r;
        if (pending_q.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
        end
        exp_r = pending_q.pop_front();
        if (got.signed_distance !== exp_r.signed_distance)
            report($sformatf("distance %0d, wanted %0d", got.signed_distance,
                exp_r.signed_distance));
        if (got.lines_parallel !== exp_r.lines_parallel)
            report($sformatf("parallel flag %b, wanted %b", got.lines_parallel,
                exp_r.lines_parallel));
    endtask
endclass

module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 120;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    twsd_pkg::t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    twsd_pkg::t_out o_out_data;
    logic i_cfg_we = 1'b0;
    logic [twsd_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    distance_scoreboard sb = new();
    int cycle_count = 0;
    bit idle_free = 1'b0;
    bit long_hold = 1'b0;
    bit hold_start = 1'b0;

    track_wire_signed_distance dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[track_wire_signed_distance] ERROR");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off, checks at each accepted item
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
        if (long_hold) i_out_ready <= 1'b0;
        else i_out_ready <= idle_free || ($urandom_range(0, 99) >= 9);
    end

    // long hold-off while the sender keeps offering items
    initial begin
        wait (hold_start);
        repeat (100) @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    task automatic write_reg(logic [twsd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        sb.write_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // valid stays high from item to item unless an idle cycle is drawn
    task automatic send_item(twsd_pkg::t_in it);
        while (!idle_free && $urandom_range(0, 99) < 9) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(it);
    endtask

    // wait for all results, then the pipeline depth
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_q(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
            default: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
        endcase
    endfunction

    function automatic twsd_pkg::t_in wire_write(logic [3:0] ly, logic [4:0] wr, int mode);
        twsd_pkg::t_in it;
        it = '0;
        it.func = twsd_pkg::FUNC_WRITE;
        it.layer = ly; it.wire_req = wr;
        it.slope_x = $urandom(); it.intercept_x = $urandom();
        it.slope_z = $urandom(); it.intercept_z = $urandom();
        it.hv_end_x = rand_q(mode); it.hv_end_y = rand_q(mode);
        it.ro_end_x = rand_q(mode); it.ro_end_y = rand_q(mode);
        return it;
    endfunction

    function automatic twsd_pkg::t_in track_item(logic [3:0] ly, logic [4:0] wr, int mode);
        twsd_pkg::t_in it;
        it = wire_write(ly, wr, 0);
        it.func = twsd_pkg::FUNC_DIST;
        it.slope_x = rand_q(mode); it.intercept_x = rand_q(mode);
        it.slope_z = rand_q(mode); it.intercept_z = rand_q(mode);
        return it;
    endfunction

    // one random phase: mostly tracks, some wire writes, all on random wires
    task automatic random_phase(int count);
        twsd_pkg::t_in it;
        int mode;
        for (int n = 0; n < count; n++) begin
            mode = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 2));
            if ($urandom_range(0, 3) == 0) it = wire_write(4'($urandom()), 5'($urandom()), mode);
            else it = track_item(4'($urandom()), 5'($urandom()), mode);
            send_item(it);
        end
    endtask

    initial begin
        twsd_pkg::t_in it;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: unwritten (zero) wire, parallel lines, extremes
        write_reg(twsd_pkg::CFG_UPPER_Y, 32'h0064_0000);
        write_reg(twsd_pkg::CFG_LOWER_Y, 32'hFF9C_0000);
        write_reg(twsd_pkg::CFG_HALF_LEN, 32'h0032_0000);
        it = '0; it.func = twsd_pkg::FUNC_DIST;
        send_item(it);
        it = wire_write(4'd3, 5'd7, 2);
        it.ro_end_x = it.hv_end_x; it.ro_end_y = it.hv_end_y;
        send_item(it);
        it = track_item(4'd3, 5'd7, 2); it.slope_x = '0; it.slope_z = '0;
        send_item(it);
        it = wire_write(4'd15, 5'd31, 0);
        it.hv_end_x = 32'h8000_0000; it.hv_end_y = 32'h7FFF_FFFF;
        it.ro_end_x = 32'h7FFF_FFFF; it.ro_end_y = 32'h8000_0000;
        send_item(it);
        it = track_item(4'd15, 5'd31, 0);
        it.slope_x = 32'h7FFF_FFFF; it.slope_z = 32'h8000_0000;
        it.intercept_x = 32'h8000_0000; it.intercept_z = 32'h7FFF_FFFF;
        send_item(it);
        it.slope_x = 32'h8000_0000; it.slope_z = 32'h7FFF_FFFF;
        it.intercept_x = 32'h7FFF_FFFF; it.intercept_z = 32'h8000_0000;
        send_item(it);
        for (int n = 0; n < 10; n++) send_item(track_item(4'd15, 5'd31, 2));
        drain();

        // zero track length: always parallel
        write_reg(twsd_pkg::CFG_UPPER_Y, 32'h0010_0000);
        write_reg(twsd_pkg::CFG_LOWER_Y, 32'h0010_0000);
        write_reg(twsd_pkg::CFG_HALF_LEN, 32'd0);
        random_phase(40);
        drain();

        // extreme registers, upper below lower
        write_reg(twsd_pkg::CFG_UPPER_Y, 32'h8000_0000);
        write_reg(twsd_pkg::CFG_LOWER_Y, 32'h7FFF_FFFF);
        write_reg(twsd_pkg::CFG_HALF_LEN, 32'h7FFF_FFFF);
        random_phase(200);
        drain();

        // typical geometry with a long hold-off, then a stretch free of idling
        write_reg(twsd_pkg::CFG_UPPER_Y, 32'h0050_0000);
        write_reg(twsd_pkg::CFG_LOWER_Y, 32'hFFB0_0000);
        write_reg(twsd_pkg::CFG_HALF_LEN, 32'h0040_0000);
        hold_start = 1'b1;
        random_phase(400);
        wait (!long_hold);
        idle_free = 1'b1;
        random_phase(300);
        idle_free = 1'b0;
        drain();

        // random registers
        for (int p = 0; p < 3; p++) begin
            write_reg(twsd_pkg::CFG_UPPER_Y, $urandom());
            write_reg(twsd_pkg::CFG_LOWER_Y, $urandom());
            write_reg(twsd_pkg::CFG_HALF_LEN, $urandom());
            random_phase(220);
            drain();
        end

        if (sb.n_errors == 0) begin
            $display("[track_wire_signed_distance] OK");
        end else begin
            $display("[track_wire_signed_distance] ERROR");
        end
        $finish;
    end
endmodule
